FILE: rtl/core/smeu_pkg.sv
// shared constants and opcode codes for the stack machine execute unit
// no dependencies
package smeu_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int VAR_COUNT_DEF = 64;
	localparam int DATA_W = 32;
	localparam int PC_W = 16;
	localparam int RTN_W = 8;
	localparam int DEPTH_W = 6;

	typedef enum logic [4:0] {
		OP_STOP = 5'd0, OP_PUSHC = 5'd1, OP_LOAD = 5'd2, OP_STORE = 5'd3,
		OP_ABS = 5'd4, OP_DEC = 5'd5, OP_INC = 5'd6, OP_ADD = 5'd7,
		OP_SUB = 5'd8, OP_MUL = 5'd9, OP_DIV = 5'd10, OP_MOD = 5'd11,
		OP_NEG = 5'd12, OP_LT = 5'd13, OP_LE = 5'd14, OP_EQ = 5'd15,
		OP_GE = 5'd16, OP_GT = 5'd17, OP_NE = 5'd18, OP_NOT = 5'd19,
		OP_OR = 5'd20, OP_AND = 5'd21, OP_JMP = 5'd22, OP_JMPF = 5'd23,
		OP_CALL = 5'd24, OP_RET = 5'd25
	} opcode_t;

endpackage

FILE: rtl/core/stack_machine_execute_unit_top.sv
// stack machine execute unit: operand stack and variable store in memories
// depends on smeu_pkg
//
// channel | dir | handshake      | payload
// in      | in  | valid / ready  | cmd operand current_pc current_routine
// out     | out | out_valid/ready| next_pc next_routine halted top_value stack_depth divide_error
//
// one word at a time; each word passes the two stack memory reads, the
// top-of-stack reread and the handshakes. call, mul, div and mod can add a
// second write; mul and a div or mod by a nonzero divisor pass exec twice.
// div and mod by a nonzero divisor run the one-bit-a-cycle divider.
// after reset a clearing pass zeroes every word of the variable
// store; no word is taken until it ends. a stalled result holds in the output
// registers and the next word is not taken until it has gone.
module stack_machine_execute_unit_top
	import smeu_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VARIABLE_COUNT = VAR_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	output logic                     ready,
	input  logic [4:0]               cmd,
	input  logic signed [DATA_W-1:0] operand,
	input  logic [PC_W-1:0]          current_pc,
	input  logic [RTN_W-1:0]         current_routine,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [PC_W-1:0]          next_pc,
	output logic [RTN_W-1:0]         next_routine,
	output logic                     halted,
	output logic signed [DATA_W-1:0] top_value,
	output logic [DEPTH_W-1:0]       stack_depth,
	output logic                     divide_error
);

	localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SC_W = $clog2(STACK_DEPTH + 1);
	localparam int VA_W = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
	localparam int VC_W = $clog2(VARIABLE_COUNT + 1);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_RDA   = 10'b0000000100,
		ST_RDB   = 10'b0000001000,
		ST_GETB  = 10'b0000010000,
		ST_EXEC  = 10'b0000100000,
		ST_DIV   = 10'b0001000000,
		ST_WR2   = 10'b0010000000,
		ST_TOP   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_W-1:0] var_mem [VARIABLE_COUNT];
	logic [DATA_W-1:0] stk_rd_q, var_rd_q;

	logic [SC_W-1:0] cnt_q;
	logic [VC_W-1:0] clr_q;
	opcode_t op_q;
	logic [4:0] cmd_q;
	logic [DATA_W-1:0] opnd_q, a_q, b_q, r_q;
	logic [PC_W-1:0] pc_q;
	logic [RTN_W-1:0] rtn_q;
	logic var_ok_q;
	logic [VA_W-1:0] vidx_q;

	// divider
	logic [DATA_W-1:0] dquo_q, drem_q, dden_q;
	logic [5:0] dstep_q;
	logic [DATA_W:0] dtrial;

	// stack memory port control
	logic st_we;
	logic [SA_W-1:0] st_wa, st_ra;
	logic [DATA_W-1:0] st_wd;
	logic v_we;
	logic [VA_W-1:0] v_wa;
	logic [DATA_W-1:0] v_wd;

	logic two_pop, one_pop, n_push, push_ok, full;
	logic wr2_go;
	logic [DATA_W-1:0] r_c;
	logic derr_c;
	logic [SC_W-1:0] cnt_pop;
	logic [DATA_W-1:0] a_abs, b_abs;

	assign ready = (state_q == ST_IDLE);

	always_comb begin
		two_pop = 1'b0;
		one_pop = 1'b0;
		unique case (op_q)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_LE, OP_EQ, OP_GE,
			OP_GT, OP_NE, OP_OR, OP_AND, OP_RET: two_pop = 1'b1;
			OP_STORE, OP_ABS, OP_DEC, OP_INC, OP_NEG, OP_NOT, OP_JMPF: one_pop = 1'b1;
			default: ;
		endcase
	end

	// pops executed count
	always_comb begin
		if (two_pop)
			cnt_pop = (cnt_q >= SC_W'(2)) ? cnt_q - SC_W'(2) : '0;
		else if (one_pop)
			cnt_pop = (cnt_q != '0) ? cnt_q - SC_W'(1) : '0;
		else
			cnt_pop = cnt_q;
	end

	assign full = (cnt_pop == SC_W'(STACK_DEPTH));
	assign a_abs = a_q[DATA_W-1] ? (DATA_W'(0) - a_q) : a_q;
	assign b_abs = b_q[DATA_W-1] ? (DATA_W'(0) - b_q) : b_q;

	always_comb begin
		r_c = '0;
		derr_c = 1'b0;
		n_push = 1'b1;
		unique case (op_q)
			OP_PUSHC: r_c = opnd_q;
			OP_LOAD:  r_c = var_ok_q ? var_rd_q : '0;
			OP_ABS:   r_c = a_abs;
			OP_DEC:   r_c = a_q - DATA_W'(1);
			OP_INC:   r_c = a_q + DATA_W'(1);
			OP_NEG:   r_c = DATA_W'(0) - a_q;
			OP_ADD:   r_c = a_q + b_q;
			OP_SUB:   r_c = a_q - b_q;
			OP_MUL:   r_c = r_q;
			OP_DIV, OP_MOD: begin
				r_c = (b_q == '0) ? '0 : r_q;
				derr_c = (b_q == '0);
			end
			OP_LT: r_c = DATA_W'($signed(a_q) < $signed(b_q));
			OP_LE: r_c = DATA_W'($signed(a_q) <= $signed(b_q));
			OP_EQ: r_c = DATA_W'(a_q == b_q);
			OP_GE: r_c = DATA_W'($signed(a_q) >= $signed(b_q));
			OP_GT: r_c = DATA_W'($signed(a_q) > $signed(b_q));
			OP_NE: r_c = DATA_W'(a_q != b_q);
			OP_NOT: r_c = DATA_W'(a_q == '0);
			OP_OR:  r_c = DATA_W'((a_q != '0) || (b_q != '0));
			OP_AND: r_c = DATA_W'((a_q != '0) && (b_q != '0));
			OP_CALL: r_c = DATA_W'(pc_q);
			default: n_push = 1'b0;
		endcase
	end

	assign push_ok = n_push && !full;
	assign dtrial = {drem_q, dden_q[DATA_W-1]} - {1'b0, b_abs};

	// call needs a second push unless the first one filled the stack
	assign wr2_go = push_ok && (((op_q == OP_CALL) && (cnt_q + SC_W'(1) != SC_W'(STACK_DEPTH)))
		|| (op_q == OP_MUL) || (op_q == OP_DIV) || (op_q == OP_MOD));

	// stack port mux
	always_comb begin
		st_we = 1'b0;
		st_wa = cnt_pop[SA_W-1:0];
		st_wd = r_c;
		st_ra = '0;
		v_we = 1'b0;
		v_wa = clr_q[VA_W-1:0];
		v_wd = '0;
		unique case (state_q)
			ST_CLEAR: v_we = 1'b1;
			ST_IDLE: st_ra = (cnt_q != '0) ? SA_W'(cnt_q - SC_W'(1)) : '0;
			ST_RDA, ST_RDB: st_ra = (cnt_q >= SC_W'(2)) ? SA_W'(cnt_q - SC_W'(2)) : '0;
			ST_EXEC: begin
				st_we = push_ok && (op_q != OP_MUL) && (op_q != OP_DIV)
					&& (op_q != OP_MOD);
				v_we = (op_q == OP_STORE) && var_ok_q;
				v_wa = vidx_q;
				v_wd = a_q;
			end
			ST_WR2: begin
				st_we = 1'b1;
				if (op_q == OP_CALL) begin
					st_wa = cnt_q[SA_W-1:0];
					st_wd = DATA_W'(rtn_q);
				end else begin
					// mul/div/mod result goes to the slot just counted
					st_wa = SA_W'(cnt_q - SC_W'(1));
					st_wd = r_q;
				end
			end
			ST_TOP: st_ra = (cnt_q != '0) ? SA_W'(cnt_q - SC_W'(1)) : '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we)
			stack_mem[st_wa] <= st_wd;
		stk_rd_q <= stack_mem[st_ra];
		if (v_we)
			var_mem[v_wa] <= v_wd;
		var_rd_q <= var_mem[vidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			clr_q <= '0;
			out_valid <= 1'b0;
			dstep_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + VC_W'(1);
					if (clr_q == VC_W'(VARIABLE_COUNT - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (valid) begin
					cmd_q <= cmd;
					op_q <= opcode_t'(cmd);
					opnd_q <= operand;
					pc_q <= current_pc;
					rtn_q <= current_routine;
					var_ok_q <= !operand[DATA_W-1] &&
						(operand < DATA_W'(VARIABLE_COUNT));
					vidx_q <= operand[VA_W-1:0];
					halted <= 1'b0;
					divide_error <= 1'b0;
					next_pc <= current_pc;
					next_routine <= current_routine;
					state_q <= ST_RDA;
				end
				ST_RDA: begin
					a_q <= (cnt_q != '0) ? stk_rd_q : '0;
					state_q <= ST_RDB;
				end
				ST_RDB: state_q <= ST_GETB;
				ST_GETB: begin
					b_q <= (cnt_q >= SC_W'(2)) ? stk_rd_q : '0;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd_q > OP_RET) begin
						halted <= 1'b1;
						state_q <= ST_TOP;
					end else if (op_q == OP_MUL && dstep_q == '0) begin
						r_q <= a_q * b_q;
						dstep_q <= 6'd1;
					end else if ((op_q == OP_DIV || op_q == OP_MOD) && dstep_q == '0
						&& b_q != '0) begin
						dden_q <= a_abs;
						drem_q <= '0;
						dquo_q <= '0;
						dstep_q <= 6'd0;
						state_q <= ST_DIV;
					end else begin
						dstep_q <= '0;
						divide_error <= derr_c;
						state_q <= wr2_go ? ST_WR2 : ST_TOP;
						unique case (op_q)
							OP_STOP: begin
								halted <= 1'b1;
								cnt_q <= cnt_pop;
							end
							OP_JMP: next_pc <= pc_q + opnd_q[PC_W-1:0];
							OP_JMPF: begin
								cnt_q <= cnt_pop;
								if (a_q == '0)
									next_pc <= pc_q + opnd_q[PC_W-1:0];
							end
							OP_CALL: begin
								next_pc <= '0;
								next_routine <= opnd_q[RTN_W-1:0];
								cnt_q <= push_ok ? cnt_q + SC_W'(1) : cnt_q;
							end
							OP_RET: begin
								if (cnt_q >= SC_W'(2)) begin
									next_routine <= a_q[RTN_W-1:0];
									next_pc <= b_q[PC_W-1:0];
									cnt_q <= cnt_pop;
								end else
									halted <= 1'b1;
							end
							OP_MUL, OP_DIV, OP_MOD: begin
								r_q <= r_c;
								cnt_q <= push_ok ? cnt_pop + SC_W'(1) : cnt_pop;
							end
							default: cnt_q <= push_ok ? cnt_pop + SC_W'(1) : cnt_pop;
						endcase
					end
				end
				ST_DIV: begin
					// restoring divide on magnitudes, one bit a cycle
					dden_q <= {dden_q[DATA_W-2:0], 1'b0};
					if (!dtrial[DATA_W]) begin
						drem_q <= dtrial[DATA_W-1:0];
						dquo_q <= {dquo_q[DATA_W-2:0], 1'b1};
					end else begin
						drem_q <= {drem_q[DATA_W-2:0], dden_q[DATA_W-1]};
						dquo_q <= {dquo_q[DATA_W-2:0], 1'b0};
					end
					dstep_q <= (dstep_q == 6'd31) ? 6'd33 : dstep_q + 6'd1;
					if (dstep_q == 6'd31)
						state_q <= ST_OUT;
				end
				ST_WR2: begin
					// second write: call routine, or the mul/div/mod result
					if (op_q == OP_CALL)
						cnt_q <= cnt_q + SC_W'(1);
					state_q <= ST_TOP;
				end
				ST_TOP: state_q <= ST_OUT;
				ST_OUT: begin
					if (dstep_q == 6'd33) begin
						// divider done: sign fixup then finish through exec
						r_q <= (op_q == OP_DIV)
							? ((a_q[DATA_W-1] ^ b_q[DATA_W-1]) ? DATA_W'(0) - dquo_q : dquo_q)
							: (a_q[DATA_W-1] ? DATA_W'(0) - drem_q : drem_q);
						dstep_q <= 6'd1;
						state_q <= ST_EXEC;
					end else if (!out_valid) begin
						top_value <= (cnt_q != '0) ? stk_rd_q : '0;
						stack_depth <= DEPTH_W'(cnt_q);
						out_valid <= 1'b1;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stack_depth <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond limit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_value))
		else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ready && out_valid))
		else $error("accept while result pending");

endmodule
